// File: rtl/signal_phase_trigger_defines.svh
// Assertion macros used by the phase trigger checker.
`ifndef SIGNAL_PHASE_TRIGGER_DEFINES_SVH
`define SIGNAL_PHASE_TRIGGER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/spt_pkg.sv
// Shared types and constants of the signal phase trigger.
`timescale 1ns / 1ps

package spt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int HOLD_BITS   = 16;
    localparam int LINE_BITS   = 4;
    localparam int MODE_BITS   = 2;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;

    localparam logic [HOLD_BITS-1:0] HOLD_RESET = HOLD_BITS'(2000);
    localparam logic [HOLD_BITS-1:0] HOLD_MAX   = {HOLD_BITS{1'b1}};

    typedef enum logic [1:0] {
        REG_DETECT_MODE = 2'd0,
        REG_HOLD_LENGTH = 2'd1,
        REG_GATE_ENABLE = 2'd2,
        REG_OUTPUT_LINE = 2'd3
    } t_reg_idx;

    localparam logic [APB_AW-1:0] ADDR_DETECT_MODE = APB_AW'(4 * REG_DETECT_MODE);

    typedef enum logic [2:0] {
        PH_NONE     = 3'd0,
        PH_FALL_POS = 3'd1,
        PH_FALL_NEG = 3'd2,
        PH_RISE_NEG = 3'd3,
        PH_RISE_POS = 3'd4
    } t_phase;

endpackage

// File: rtl/signal_phase_trigger.sv
// Signal phase trigger: phase tracking, trigger hold and gating on a sample stream.
`timescale 1ns / 1ps

// One signed sample per beat enters an input register; one compare-and-count pass
// classifies the phase, updates the trigger and hold counter, and loads the result
// register. Every sample gives exactly one result beat, one beat per cycle while the
// sink takes them; the result register is loaded from the input register once the
// output has room. The input stalls only while both the input and the result register
// hold a beat and the sink holds i_out_ready low. Registers sit on an
// APB-style port: detect_mode at 0x0, hold_length at 0x4, gate_enable at 0x8,
// output_line at 0xC. Write them only while no sample is in flight.
module signal_phase_trigger (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [spt_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic                               i_gate_level,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_event_valid,
    output logic                               o_event_on,
    output logic [spt_pkg::LINE_BITS-1:0]      o_event_line,
    output logic [2:0]                         o_phase_now,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spt_pkg::APB_AW-1:0]         paddr,
    input  logic [spt_pkg::APB_DW-1:0]         pwdata,
    output logic [spt_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import spt_pkg::*;

    // configuration
    logic [MODE_BITS-1:0] r_detect_mode;
    logic [HOLD_BITS-1:0] r_hold_length;
    logic                 r_gate_enable;
    logic [LINE_BITS-1:0] r_output_line;

    // input stage
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_gate;

    // tracking state
    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    t_phase                        r_phase, n_phase, entered;
    logic                          r_active, n_active;
    logic [HOLD_BITS-1:0]          r_hold_cnt, n_hold_cnt;

    // result stage
    logic                 r_out_valid;
    logic                 r_ev_valid, n_ev_valid;
    logic                 r_ev_on, n_ev_on;
    logic [LINE_BITS-1:0] r_ev_line;
    t_phase               r_ph_out;

    logic     out_free, advance, gated, hit, cfg_wr;
    t_reg_idx wr_idx;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_comb begin
        unique case (wr_idx)
            REG_DETECT_MODE: prdata = APB_DW'(r_detect_mode);
            REG_HOLD_LENGTH: prdata = APB_DW'(r_hold_length);
            REG_GATE_ENABLE: prdata = APB_DW'(r_gate_enable);
            REG_OUTPUT_LINE: prdata = APB_DW'(r_output_line);
            default:         prdata = '0;
        endcase
    end

    // phase rules, first match wins
    always_comb begin
        logic s_pos, s_neg, p_nonneg, p_nonpos;
        s_pos    = (r_in_sample > 0);
        s_neg    = r_in_sample[SAMPLE_BITS-1];
        p_nonneg = !r_prev[SAMPLE_BITS-1];
        p_nonpos = r_prev[SAMPLE_BITS-1] || (r_prev == '0);
        priority if ((r_in_sample < r_prev) && s_pos && (r_phase != PH_FALL_POS))
            entered = PH_FALL_POS;
        else if (s_neg && p_nonneg && (r_phase != PH_FALL_NEG))
            entered = PH_FALL_NEG;
        else if ((r_in_sample > r_prev) && s_neg && (r_phase != PH_RISE_NEG))
            entered = PH_RISE_NEG;
        else if (s_pos && p_nonpos && (r_phase != PH_RISE_POS))
            entered = PH_RISE_POS;
        else
            entered = PH_NONE;
    end

    assign gated = r_gate_enable && !r_in_gate;
    assign hit   = (entered != PH_NONE) && (entered == t_phase'({1'b0, r_detect_mode} + 3'd1));

    always_comb begin
        n_prev     = r_prev;
        n_phase    = r_phase;
        n_active   = r_active;
        n_hold_cnt = r_hold_cnt;
        n_ev_valid = 1'b0;
        n_ev_on    = 1'b0;
        if (gated) begin
            // drop the sample, switch an active output off at once
            n_active   = 1'b0;
            n_ev_valid = r_active;
        end else begin
            n_prev = r_in_sample;
            if (entered != PH_NONE) begin
                n_phase = entered;
            end
            if (hit) begin
                // restart hold; the count step of this beat lands it at one
                n_active   = 1'b1;
                n_hold_cnt = HOLD_BITS'(1);
                n_ev_valid = 1'b1;
                n_ev_on    = 1'b1;
            end else if (r_active) begin
                if (r_hold_cnt > r_hold_length) begin
                    n_active   = 1'b0;
                    n_ev_valid = 1'b1;
                end else if (r_hold_cnt != HOLD_MAX) begin
                    n_hold_cnt = r_hold_cnt + HOLD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_mode <= '0;
            r_hold_length <= HOLD_RESET;
            r_gate_enable <= 1'b0;
            r_output_line <= '0;
        end else if (cfg_wr) begin
            unique case (wr_idx)
                REG_DETECT_MODE: r_detect_mode <= pwdata[MODE_BITS-1:0];
                REG_HOLD_LENGTH: r_hold_length <= pwdata[HOLD_BITS-1:0];
                REG_GATE_ENABLE: r_gate_enable <= pwdata[0];
                REG_OUTPUT_LINE: r_output_line <= pwdata[LINE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_phase     <= PH_NONE;
            r_active    <= 1'b0;
            r_hold_cnt  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_prev;
                r_phase     <= n_phase;
                r_active    <= n_active;
                r_hold_cnt  <= n_hold_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_sample <= i_sample_value;
            r_in_gate   <= i_gate_level;
        end
        if (advance) begin
            r_ev_valid <= n_ev_valid;
            r_ev_on    <= n_ev_on;
            r_ev_line  <= n_ev_valid ? r_output_line : '0;
            r_ph_out   <= n_phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_ev_valid;
    assign o_event_on    = r_ev_on;
    assign o_event_line  = r_ev_line;
    assign o_phase_now   = r_ph_out;

endmodule

// File: rtl/spt_checker.sv
// Port-level checks of the signal phase trigger, bound to the top level.
`timescale 1ns / 1ps
`include "signal_phase_trigger_defines.svh"

module spt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_event_valid,
    input logic                               o_event_on,
    input logic [spt_pkg::LINE_BITS-1:0]      o_event_line,
    input logic [2:0]                         o_phase_now,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [spt_pkg::APB_AW-1:0]         paddr,
    input logic [spt_pkg::APB_DW-1:0]         pwdata,
    input logic [spt_pkg::APB_DW-1:0]         prdata,
    input logic                               pready
);
    import spt_pkg::*;

    // a beat without an event carries no on flag and no line
    `SPT_ASSERT_NOW(a_quiet_beat, o_out_valid && !o_event_valid, !o_event_on && (o_event_line == '0), "event fields set without an event")

    // input stalls only behind a full, stalled result register
    `SPT_ASSERT_NOW(a_stall_cause, !o_in_ready, o_out_valid && !i_out_ready, "input stalled with room at the output")

    // a stalled result beat holds
    `SPT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_event_valid) && $stable(o_event_on) && $stable(o_event_line) && $stable(o_phase_now), "result changed while stalled")

    // a mode write reads back
    `SPT_ASSERT_NOW(a_mode_readback, $past(i_rst_n) && $past(psel && penable && pwrite && pready && (paddr == ADDR_DETECT_MODE)) && (paddr == ADDR_DETECT_MODE), (prdata[1:0] == $past(pwdata[1:0])) && (prdata[31:2] == '0), "detect_mode readback mismatch")

endmodule

bind signal_phase_trigger spt_checker u_spt_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the signal phase trigger: directed table, hold soak, random waves.
`timescale 1ns / 1ps
module tb;
    import spt_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 6;
    localparam int LATENCY         = 2;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SOAK_BEATS      = 100;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int RAND_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 125;
    localparam int MAX_PRINTS      = 40;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                 ev_valid;
        logic                 ev_on;
        logic [LINE_BITS-1:0] ev_line;
        t_phase               phase;
    } trig_res_t;

    typedef enum logic [0:0] {
        ROW_BEAT,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_reg_idx  reg_idx;
        int        value;
        logic      gate;
        logic      typed;
        trig_res_t want;
    } dir_row_t;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    sample_t               i_sample_value = '0;
    logic                  i_gate_level   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_event_valid;
    logic                  o_event_on;
    logic [LINE_BITS-1:0]  o_event_line;
    logic [2:0]            o_phase_now;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_AW-1:0]     paddr          = '0;
    logic [APB_DW-1:0]     pwdata         = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Tags that travel with a beat whose result is typed into the table
    logic                  beat_typed     = 1'b0;
    trig_res_t             beat_want      = '0;

    // Trigger predictor: configuration and state
    logic [MODE_BITS-1:0]  cfg_mode       = '0;
    logic [HOLD_BITS-1:0]  cfg_hold       = HOLD_RESET;
    logic                  cfg_gate_en    = 1'b0;
    logic [LINE_BITS-1:0]  cfg_line       = '0;
    sample_t               last_sample    = '0;
    t_phase                cur_phase      = PH_NONE;
    logic                  trig_on        = 1'b0;
    logic [HOLD_BITS-1:0]  hold_cnt       = '0;

    trig_res_t             pending_q[$];
    dir_row_t              dir_q[$];

    bit                    hold_off_req   = 1'b0;
    bit                    rx_open        = 1'b0;
    int                    wave_val       = 0;
    int                    wave_dir       = 1;
    int                    wave_amp       = 40;
    bit                    gate_now       = 1'b1;

    int                    err_cnt        = 0;
    int                    cycle_cnt      = 0;
    int                    n_beats        = 0;
    int                    n_results      = 0;
    int                    n_on           = 0;
    int                    n_off          = 0;
    int                    n_writes       = 0;
    int                    n_hold_offs    = 0;
    int                    n_in_stalls    = 0;

    signal_phase_trigger i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_gate_level   (i_gate_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_valid  (o_event_valid),
        .o_event_on     (o_event_on),
        .o_event_line   (o_event_line),
        .o_phase_now    (o_phase_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, pending_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Advance the phase tracker and trigger by one sample; return the result beat.
    function automatic trig_res_t next_trigger(sample_t s, logic g);
        trig_res_t r;
        t_phase    entered;
        logic      fire;
        logic      fire_on;
        r       = '0;
        entered = PH_NONE;
        fire    = 1'b0;
        fire_on = 1'b0;
        if (cfg_gate_en && !g) begin
            // gated: freeze tracking, drop an active output at once
            if (trig_on) begin
                trig_on = 1'b0;
                fire    = 1'b1;
            end
        end else begin
            if (s < last_sample && s > 0 && cur_phase != PH_FALL_POS)
                entered = PH_FALL_POS;
            else if (s < 0 && last_sample >= 0 && cur_phase != PH_FALL_NEG)
                entered = PH_FALL_NEG;
            else if (s > last_sample && s < 0 && cur_phase != PH_RISE_NEG)
                entered = PH_RISE_NEG;
            else if (s > 0 && last_sample <= 0 && cur_phase != PH_RISE_POS)
                entered = PH_RISE_POS;
            if (entered != PH_NONE) begin
                if (entered == t_phase'(3'(cfg_mode) + 3'd1)) begin
                    fire     = 1'b1;
                    fire_on  = 1'b1;
                    trig_on  = 1'b1;
                    hold_cnt = '0;
                end
                cur_phase = entered;
            end
            last_sample = s;
            if (trig_on) begin
                if (hold_cnt > cfg_hold) begin
                    trig_on = 1'b0;
                    fire    = 1'b1;
                    fire_on = 1'b0;
                end else if (hold_cnt != HOLD_MAX) begin
                    hold_cnt++;
                end
            end
        end
        r.ev_valid = fire;
        r.ev_on    = fire && fire_on;
        r.ev_line  = fire ? cfg_line : '0;
        r.phase    = cur_phase;
        return r;
    endfunction

    // Predict on input beats, check output beats against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        trig_res_t got;
        trig_res_t want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready)
                n_in_stalls++;
            if (i_in_valid && o_in_ready) begin
                want = next_trigger(i_sample_value, i_gate_level);
                if (beat_typed)
                    want = beat_want;
                pending_q.push_back(want);
                n_beats++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_event_valid, o_event_on, o_event_line, t_phase'(o_phase_now)};
                n_results++;
                if (got.ev_valid && got.ev_on)
                    n_on++;
                if (got.ev_valid && !got.ev_on)
                    n_off++;
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = pending_q.pop_front();
                    if (got.ev_valid !== want.ev_valid)
                        report_mismatch("event_valid", got.ev_valid, want.ev_valid);
                    if (got.ev_on !== want.ev_on)
                        report_mismatch("event_on", got.ev_on, want.ev_on);
                    if (got.ev_line !== want.ev_line)
                        report_mismatch("event_line", got.ev_line, want.ev_line);
                    if (got.phase !== want.phase)
                        report_mismatch("phase_now", int'(got.phase), int'(want.phase));
                end
            end
        end
    end

    // Receiver: stall patterns in segments, plus a long hold-off on request.
    initial begin : sink
        int seg_len;
        int kind;
        forever begin
            kind    = $urandom_range(0, 3);
            seg_len = $urandom_range(8, 80);
            for (int k = 0; k < seg_len; k++) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    n_hold_offs++;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                end
                if (rx_open || kind == 0)
                    i_out_ready <= 1'b1;
                else if (kind == 1)
                    i_out_ready <= 1'($urandom_range(0, 1));
                else if (kind == 2)
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                else
                    i_out_ready <= ((k % 8) < 5);
            end
        end
    end

    // Hold valid and payload until the beat is taken.
    task automatic put_beat(sample_t s, logic g, logic typed, trig_res_t want);
        i_in_valid     <= 1'b1;
        i_sample_value <= s;
        i_gate_level   <= g;
        beat_typed     <= typed;
        beat_want      <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Write a register, then read it back.
    task automatic reg_write(t_reg_idx idx, logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] want_rd;
        want_rd = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_DETECT_MODE: begin
                cfg_mode = val[MODE_BITS-1:0];
                want_rd[MODE_BITS-1:0] = cfg_mode;
            end
            REG_HOLD_LENGTH: begin
                cfg_hold = val[HOLD_BITS-1:0];
                want_rd[HOLD_BITS-1:0] = cfg_hold;
            end
            REG_GATE_ENABLE: begin
                cfg_gate_en = val[0];
                want_rd[0]  = cfg_gate_en;
            end
            REG_OUTPUT_LINE: begin
                cfg_line = val[LINE_BITS-1:0];
                want_rd[LINE_BITS-1:0] = cfg_line;
            end
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        n_writes++;
        if (rd !== want_rd)
            report_mismatch("register read-back", int'(rd), int'(want_rd));
    endtask

    function automatic dir_row_t row_wr(t_reg_idx idx, int val);
        dir_row_t r;
        r = '{ROW_WRITE, idx, val, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic dir_row_t row_bt(int s, logic g);
        dir_row_t r;
        r = '{ROW_BEAT, REG_DETECT_MODE, s, g, 1'b0, '0};
        return r;
    endfunction

    function automatic dir_row_t row_ck(int s, logic g, logic v, logic on, int line, t_phase ph);
        dir_row_t r;
        r = '{ROW_BEAT, REG_DETECT_MODE, s, g, 1'b1,
              '{v, on, LINE_BITS'(line), ph}};
        return r;
    endfunction

    // Triangle-like wave with random slope and occasional turns.
    function automatic sample_t next_wave();
        int step;
        step = $urandom_range(1, wave_amp / 3 + 1);
        if ($urandom_range(0, 9) == 0)
            wave_dir = -wave_dir;
        wave_val += wave_dir * step;
        if (wave_val >= wave_amp) begin
            wave_val = wave_amp;
            wave_dir = -1;
        end else if (wave_val <= -wave_amp) begin
            wave_val = -wave_amp;
            wave_dir = 1;
        end
        return sample_t'(wave_val);
    endfunction

    task automatic run_stream(int count, bit with_gaps, int hold_off_at);
        int      sent;
        int      burst;
        int      kind;
        sample_t s;
        sample_t prev_s;
        sent   = 0;
        prev_s = '0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            kind  = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    wave_amp = $urandom_range(1, 60);
                    2:       wave_amp = $urandom_range(100, 32767);
                    default: wave_amp = 32767;
                endcase
                wave_val = 0;
            end
            for (int k = 0; k < burst && sent < count; k++) begin
                if (sent == hold_off_at)
                    hold_off_req = 1'b1;
                if (kind <= 6)
                    s = next_wave();
                else if (kind == 7)
                    s = sample_t'($urandom);
                else if (kind == 8)
                    s = sample_t'(int'($urandom_range(0, 6)) - 3);
                else
                    s = prev_s;
                // gate mostly open, closed in short runs
                if ($urandom_range(0, gate_now ? 15 : 3) == 0)
                    gate_now = !gate_now;
                put_beat(s, gate_now, 1'b0, '0);
                prev_s = s;
                sent++;
            end
            if (with_gaps && sent < count && $urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stim
        dir_row_t             row;
        logic [HOLD_BITS-1:0] hold_v;
        logic [LINE_BITS-1:0] line_v;

        dir_q = '{
            row_ck(0, 1'b1, 1'b0, 1'b0, 0, PH_NONE),
            row_ck(32767, 1'b1, 1'b0, 1'b0, 0, PH_RISE_POS),
            row_ck(100, 1'b1, 1'b1, 1'b1, 0, PH_FALL_POS),
            row_ck(-32768, 1'b1, 1'b0, 1'b0, 0, PH_FALL_NEG),
            row_bt(-1, 1'b1),
            row_wr(REG_OUTPUT_LINE, 15),
            row_wr(REG_GATE_ENABLE, 1),
            row_ck(5, 1'b0, 1'b1, 1'b0, 15, PH_RISE_NEG),
            row_ck(5, 1'b0, 1'b0, 1'b0, 0, PH_RISE_NEG),
            row_wr(REG_DETECT_MODE, 3),
            row_wr(REG_HOLD_LENGTH, 0),
            row_bt(5, 1'b1),
            row_bt(5, 1'b1),
            row_wr(REG_DETECT_MODE, 1),
            row_bt(-7, 1'b1),
            row_bt(-7, 1'b1),
            row_wr(REG_DETECT_MODE, 2),
            row_bt(-20, 1'b1),
            row_bt(-3, 1'b1),
            row_bt(-3, 1'b1),
            row_wr(REG_HOLD_LENGTH, 10),
            row_wr(REG_DETECT_MODE, 0),
            row_bt(10, 1'b1),
            row_bt(5, 1'b1),
            row_bt(9, 1'b1),
            row_bt(-1, 1'b1),
            row_bt(3, 1'b1),
            row_bt(2, 1'b1),
            row_wr(REG_GATE_ENABLE, 0),
            row_bt(1, 1'b0)
        };

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_q[i]) begin
            row = dir_q[i];
            if (row.kind == ROW_WRITE) begin
                wait_drained();
                reg_write(row.reg_idx, APB_DW'(row.value));
            end else begin
                put_beat(sample_t'(row.value), row.gate, row.typed, row.want);
            end
        end
        wait_drained();

        // Hold the output on with the longest hold, then shorten it; it stays on.
        rx_open = 1'b1;
        reg_write(REG_DETECT_MODE, APB_DW'(3));
        reg_write(REG_HOLD_LENGTH, APB_DW'(HOLD_MAX));
        put_beat(-5, 1'b1, 1'b0, '0);
        put_beat(5, 1'b1, 1'b0, '0);
        for (int k = 0; k < SOAK_BEATS; k++)
            put_beat(5, 1'b1, 1'b0, '0);
        wait_drained();
        reg_write(REG_HOLD_LENGTH, APB_DW'(HOLD_MAX - 1));
        put_beat(5, 1'b1, 1'b0, '0);
        wait_drained();
        rx_open = 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       hold_v = '0;
                1:       hold_v = HOLD_MAX - 1;
                5:       hold_v = HOLD_BITS'($urandom_range(100, 3000));
                default: hold_v = HOLD_BITS'($urandom_range(0, 40));
            endcase
            case (p)
                0:       line_v = '0;
                1:       line_v = '1;
                default: line_v = LINE_BITS'($urandom);
            endcase
            reg_write(REG_DETECT_MODE, {30'($urandom), 2'(p % 4)});
            reg_write(REG_HOLD_LENGTH, {16'($urandom), hold_v});
            reg_write(REG_GATE_ENABLE, {31'($urandom), 1'(p % 2)});
            reg_write(REG_OUTPUT_LINE, {28'($urandom), line_v});
            // phase 3 runs without gaps and holds the sink off partway through
            run_stream(BEATS_PER_PHASE, (p % 3) != 0, (p == 3) ? 30 : -1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0)
            report_mismatch("results never delivered", 0, pending_q.size());

        $display("Run covered %0d sample beats and %0d results: %0d trigger-on, %0d trigger-off.",
                 n_beats, n_results, n_on, n_off);
        $display("Register writes %0d, sink hold-offs %0d, input stall cycles %0d.",
                 n_writes, n_hold_offs, n_in_stalls);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/spt_pkg.sv
rtl/signal_phase_trigger.sv
rtl/spt_checker.sv
tb/sv/tb.sv
